FILE: hdl/primality_trial_division_unit_assert.svh
// assertion macros shared by the primality trial division unit
// depends on: nothing; files that assert take it by include
`ifndef PRIMALITY_TRIAL_DIVISION_UNIT_ASSERT_SVH
`define PRIMALITY_TRIAL_DIVISION_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// checked property, suspended while reset is active
`define PTD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("primality unit: assertion failed");
// checked property, also evaluated during reset
`define PTD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("primality unit: assertion failed");
`else
`define PTD_ASSERT(lbl, clk, rstn, prop)
`define PTD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/ptd_pkg.sv
// package of the primality trial division unit: sequencer state and constants
// depends on: nothing
package ptd_pkg;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV3 = 5'b00010,
    ST_DIVA = 5'b00100,
    ST_DIVB = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  // largest value decided by comparison alone, without division
  localparam int unsigned SmallMax  = 3;
  // first divisor of the 6k-1 / 6k+1 sequence
  localparam int unsigned FirstDiv  = 5;
  // step from 6k-1 to 6k+1 and from 6k+1 to the next 6k-1
  localparam int unsigned PairStep  = 2;
  localparam int unsigned NextStep  = 4;
  // divisor used for the multiple-of-three check
  localparam int unsigned ThreeDiv  = 3;

endpackage

FILE: hdl/ptd_if.sv
// handshake channels of the primality trial division unit
// depends on: nothing
interface ptd_num_if #(
  parameter int unsigned NUM_WIDTH = 31
) ();
  logic                 valid;
  logic                 ready;
  logic [NUM_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface ptd_res_if ();
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

FILE: hdl/primality_trial_division_unit.sv
// Primality test by trial division over 6k-1 / 6k+1 divisors. One transaction
// on num_i carries a number; one transaction on res_o answers whether it is
// prime. A single restoring divider produces one quotient bit per cycle, and
// each trial division runs over all NUM_WIDTH dividend bits. Numbers up to 3
// and even numbers are decided on acceptance, without division; others take
// the check by 3 and one division for each trial divisor, the last 6k-1 pass
// of a prime only finding that d*d exceeds the number. A prime takes about
// sqrt(number)/3 trial divisions. The unit holds one number at a time:
// num_i.ready is high only while no number is in work and no result waits.
//
// depends on: ptd_pkg, ptd_if, primality_trial_division_unit_assert.svh
`include "primality_trial_division_unit_assert.svh"

module primality_trial_division_unit #(
  parameter int unsigned NUM_WIDTH = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptd_num_if.sink    num_i,
  ptd_res_if.source  res_o
);

  localparam int unsigned CntW = $clog2(NUM_WIDTH);

  ptd_pkg::state_e      state_q, state_d;
  logic [NUM_WIDTH-1:0] num_q, num_d;
  logic [NUM_WIDTH-1:0] div_q, div_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [NUM_WIDTH-1:0] quo_q, quo_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 prime_q, prime_d;

  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic                 fits;
  logic                 last_step;

  // shared divider step: shift in one dividend bit, subtract if it fits
  assign trial     = {rem_q, quo_q[NUM_WIDTH-1]};
  assign diff      = trial - {1'b0, div_q};
  assign fits      = !diff[NUM_WIDTH];
  assign last_step = (cnt_q == '0);

  always_comb begin
    rem_d = fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
    quo_d = {quo_q[NUM_WIDTH-2:0], fits};
    cnt_d = cnt_q - CntW'(1);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    div_d   = div_q;
    prime_d = prime_q;
    unique case (state_q)
      ptd_pkg::ST_IDLE: begin
        if (num_i.valid) begin
          num_d = num_i.number;
          if (num_i.number <= NUM_WIDTH'(ptd_pkg::SmallMax)) begin
            prime_d = (num_i.number > NUM_WIDTH'(1));
            state_d = ptd_pkg::ST_DONE;
          end else if (!num_i.number[0]) begin
            prime_d = 1'b0;
            state_d = ptd_pkg::ST_DONE;
          end else begin
            div_d   = NUM_WIDTH'(ptd_pkg::ThreeDiv);
            state_d = ptd_pkg::ST_DIV3;
          end
        end
      end
      ptd_pkg::ST_DIV3: begin
        if (last_step) begin
          if (rem_d == '0) begin
            prime_d = 1'b0;
            state_d = ptd_pkg::ST_DONE;
          end else begin
            div_d   = NUM_WIDTH'(ptd_pkg::FirstDiv);
            state_d = ptd_pkg::ST_DIVA;
          end
        end
      end
      ptd_pkg::ST_DIVA: begin
        if (last_step) begin
          // d*d > n exactly when n/d < d
          if (quo_d < div_q) begin
            prime_d = 1'b1;
            state_d = ptd_pkg::ST_DONE;
          end else if (rem_d == '0) begin
            prime_d = 1'b0;
            state_d = ptd_pkg::ST_DONE;
          end else begin
            div_d   = div_q + NUM_WIDTH'(ptd_pkg::PairStep);
            state_d = ptd_pkg::ST_DIVB;
          end
        end
      end
      ptd_pkg::ST_DIVB: begin
        if (last_step) begin
          if (rem_d == '0) begin
            prime_d = 1'b0;
            state_d = ptd_pkg::ST_DONE;
          end else begin
            div_d   = div_q + NUM_WIDTH'(ptd_pkg::NextStep);
            state_d = ptd_pkg::ST_DIVA;
          end
        end
      end
      ptd_pkg::ST_DONE: begin
        if (res_o.ready) begin
          state_d = ptd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptd_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers; a new division starts whenever the divisor is loaded
  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    div_q   <= div_d;
    prime_q <= prime_d;
    if (state_d != state_q || (state_q == ptd_pkg::ST_DIVA && state_d == ptd_pkg::ST_DIVA
                               && last_step)) begin
      rem_q <= '0;
      quo_q <= num_d;
      cnt_q <= CntW'(NUM_WIDTH - 1);
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_d;
    end
  end

  assign num_i.ready    = (state_q == ptd_pkg::ST_IDLE);
  assign res_o.valid    = (state_q == ptd_pkg::ST_DONE);
  assign res_o.is_prime = prime_q;

  // checks
  `PTD_ASSERT_ALWAYS(a_not_both_sides, clk_i, !(num_i.ready && res_o.valid))
  `PTD_ASSERT(a_accept_leaves_idle, clk_i, rst_ni,
              num_i.valid && num_i.ready |=> state_q != ptd_pkg::ST_IDLE)
  `PTD_ASSERT(a_result_frees_unit, clk_i, rst_ni,
              res_o.valid && res_o.ready |=> num_i.ready)
  `PTD_ASSERT(a_odd_trial_divisor, clk_i, rst_ni,
              (state_q == ptd_pkg::ST_DIVA || state_q == ptd_pkg::ST_DIVB) |-> div_q[0])
  `PTD_ASSERT(a_prime_is_odd_or_two, clk_i, rst_ni,
              res_o.valid && res_o.is_prime |-> num_q[0] || num_q == NUM_WIDTH'(2))

endmodule
